// File: rtl/core/wmam_pkg.sv
// Shared types and constants for the wide multiply-add-remainder accumulator.
// No dependencies; imported by every module of the block.
package wmam_pkg;

  localparam int unsigned WordW    = 64;
  localparam int unsigned MulSteps = WordW;        // one multiplier bit per step
  localparam int unsigned RemSteps = 2 * WordW;    // one dividend bit per step
  localparam int unsigned CntW     = $clog2(RemSteps);

  typedef enum logic [1:0] {
    FUNC_MUL = 2'd0,
    FUNC_ADD = 2'd1,
    FUNC_REM = 2'd2,
    FUNC_GET = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD_LO,
    ST_ADD_HI,
    ST_REM,
    ST_DONE
  } state_e;

  typedef enum logic [2:0] {
    STEP_NONE,
    STEP_MUL,
    STEP_ADD_LO,
    STEP_ADD_HI,
    STEP_REM
  } step_e;

  typedef struct packed {
    step_e step;    // which use of the shared adder this cycle
    logic  last;    // final iteration of a multi-step operation
    logic  finish;  // result moves into the output register
  } ctrl_t;

endpackage

// File: rtl/core/wmam_adder.sv
// Shared 64-bit adder with carry in and carry out.
// Depends on wmam_pkg for the word width.
module wmam_adder
  import wmam_pkg::*;
(
  input  logic [WordW-1:0] a_i,
  input  logic [WordW-1:0] b_i,
  input  logic             cin_i,
  output logic [WordW-1:0] sum_o,
  output logic             cout_o
);

  logic [WordW:0] sum_full;

  assign sum_full = {1'b0, a_i} + {1'b0, b_i} + {{WordW{1'b0}}, cin_i};
  assign sum_o    = sum_full[WordW-1:0];
  assign cout_o   = sum_full[WordW];

endmodule

// File: rtl/core/wmam_ctrl.sv
// Sequencer: operation state machine and iteration counter.
// Depends on wmam_pkg for state, step and control types.
module wmam_ctrl
  import wmam_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  func_e func_i,
  input  logic  div_zero_i,
  input  logic  out_free_i,
  output logic  idle_o,
  output ctrl_t ctrl_o
);

  state_e         state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            last;

  always_comb begin
    last = 1'b0;
    case (state_q)
      ST_MUL:  last = (cnt_q == CntW'(MulSteps - 1));
      ST_REM:  last = (cnt_q == CntW'(RemSteps - 1));
      default: last = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (func_i)
            FUNC_MUL: state_d = ST_MUL;
            FUNC_ADD: state_d = ST_ADD_LO;
            FUNC_REM: state_d = div_zero_i ? ST_DONE : ST_REM;
            default:  state_d = ST_DONE;
          endcase
        end
      end
      ST_MUL:    if (last) state_d = ST_DONE;
      ST_ADD_LO: state_d = ST_ADD_HI;
      ST_ADD_HI: state_d = ST_DONE;
      ST_REM:    if (last) state_d = ST_DONE;
      ST_DONE:   if (out_free_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o.step   = STEP_NONE;
    ctrl_o.last   = last;
    ctrl_o.finish = 1'b0;
    idle_o        = 1'b0;
    cnt_d         = cnt_q;
    case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        cnt_d  = '0;
      end
      ST_MUL: begin
        ctrl_o.step = STEP_MUL;
        cnt_d       = cnt_q + 1'b1;
      end
      ST_ADD_LO: ctrl_o.step = STEP_ADD_LO;
      ST_ADD_HI: ctrl_o.step = STEP_ADD_HI;
      ST_REM: begin
        ctrl_o.step = STEP_REM;
        cnt_d       = cnt_q + 1'b1;
      end
      ST_DONE: ctrl_o.finish = out_free_i;
      default: ctrl_o.step = STEP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: rtl/core/wide_mul_add_mod_accumulator_core.sv
// Top level of the 128-bit multiply / add / remainder accumulator.
// Depends on wmam_pkg, wmam_adder and wmam_ctrl.
//
//   channel | handshake                 | payload
//   --------+---------------------------+-----------------------------------------
//   input   | in_valid_i  / in_ready_o  | func_i first_operand_i second_operand_i
//   result  | out_valid_o / out_ready_i | low_word_o high_word_o divide_by_zero_o
//
// Between accepts the sequencer runs multiply steps, add low then add high, or
// remainder steps; remainder by zero and read go straight to the result, which
// loads as the sequencer returns to idle. One shared 64-bit adder sets the pace:
// shift-add multiply and restoring remainder each take one bit a cycle.
// in_ready_o is high only while the sequencer is idle; a waiting result stalls
// only the next transaction's completion. Reset clears accumulator and control.
module wide_mul_add_mod_accumulator_core
  import wmam_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       func_i,
  input  logic [WordW-1:0] first_operand_i,
  input  logic [WordW-1:0] second_operand_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WordW-1:0] low_word_o,
  output logic [WordW-1:0] high_word_o,
  output logic             divide_by_zero_o
);

  logic             in_accept;
  logic             idle;
  logic             out_free;
  logic             div_zero;
  ctrl_t            ctrl;
  func_e            func_in;

  // accumulator doubles as product / dividend shift register
  logic [WordW-1:0] acc_lo_q, acc_lo_d;
  logic [WordW-1:0] acc_hi_q, acc_hi_d;
  logic [WordW-1:0] opa_q, opa_d;       // multiplicand, addend or divisor
  logic [WordW-1:0] rem_q, rem_d;       // partial remainder
  logic             carry_q, carry_d;   // add carry from low to high word
  logic             dz_q, dz_d;
  func_e            func_q, func_d;

  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_lo_q, out_hi_q;
  logic             out_dz_q;

  // shared adder operands
  logic [WordW-1:0] add_a, add_b, add_sum;
  logic             add_cin, add_cout;

  logic [WordW-1:0] rem_shift;
  logic             rem_top;

  assign func_in    = func_e'(func_i);
  assign in_ready_o = idle;
  assign in_accept  = in_valid_i & in_ready_o;
  assign div_zero   = (first_operand_i == '0);
  assign out_free   = !out_valid_q || out_ready_i;

  assign rem_top   = rem_q[WordW-1];
  assign rem_shift = {rem_q[WordW-2:0], acc_hi_q[WordW-1]};

  wmam_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .func_i     (func_in),
    .div_zero_i (div_zero),
    .out_free_i (out_free),
    .idle_o     (idle),
    .ctrl_o     (ctrl)
  );

  // adder operand select
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    case (ctrl.step)
      STEP_MUL: begin
        add_a = acc_hi_q;
        add_b = acc_lo_q[0] ? opa_q : '0;
      end
      STEP_ADD_LO: begin
        add_a = acc_lo_q;
        add_b = opa_q;
      end
      STEP_ADD_HI: begin
        add_a   = acc_hi_q;
        add_cin = carry_q;
      end
      STEP_REM: begin
        // shifted remainder minus divisor; carry out means no borrow
        add_a   = rem_shift;
        add_b   = ~opa_q;
        add_cin = 1'b1;
      end
      default: add_a = '0;
    endcase
  end

  wmam_adder u_adder (
    .a_i    (add_a),
    .b_i    (add_b),
    .cin_i  (add_cin),
    .sum_o  (add_sum),
    .cout_o (add_cout)
  );

  // datapath next state
  always_comb begin
    acc_lo_d = acc_lo_q;
    acc_hi_d = acc_hi_q;
    opa_d    = opa_q;
    rem_d    = rem_q;
    carry_d  = carry_q;
    dz_d     = dz_q;
    func_d   = func_q;

    if (in_accept) begin
      opa_d  = first_operand_i;
      rem_d  = '0;
      func_d = func_in;
      dz_d   = (func_in == FUNC_REM) && div_zero;
      if (func_in == FUNC_MUL) begin
        // multiplier rides in the low word, product builds from the top
        acc_lo_d = second_operand_i;
        acc_hi_d = '0;
      end
    end

    case (ctrl.step)
      STEP_MUL: begin
        acc_hi_d = {add_cout, add_sum[WordW-1:1]};
        acc_lo_d = {add_sum[0], acc_lo_q[WordW-1:1]};
      end
      STEP_ADD_LO: begin
        acc_lo_d = add_sum;
        carry_d  = add_cout;
      end
      STEP_ADD_HI: acc_hi_d = add_sum;
      STEP_REM: begin
        rem_d    = (rem_top || add_cout) ? add_sum : rem_shift;
        // dividend shifts out the top; zeros fill, so the high word ends clear
        acc_hi_d = {acc_hi_q[WordW-2:0], acc_lo_q[WordW-1]};
        acc_lo_d = {acc_lo_q[WordW-2:0], 1'b0};
        if (ctrl.last) begin
          acc_lo_d = rem_d;
        end
      end
      default: carry_d = carry_q;
    endcase
  end

  assign out_valid_d = ctrl.finish ? 1'b1 : (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_lo_q    <= '0;
      acc_hi_q    <= '0;
      out_valid_q <= 1'b0;
      carry_q     <= 1'b0;
      dz_q        <= 1'b0;
      func_q      <= FUNC_GET;
    end else begin
      acc_lo_q    <= acc_lo_d;
      acc_hi_q    <= acc_hi_d;
      out_valid_q <= out_valid_d;
      carry_q     <= carry_d;
      dz_q        <= dz_d;
      func_q      <= func_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q <= opa_d;
    rem_q <= rem_d;
    if (ctrl.finish) begin
      out_lo_q <= acc_lo_q;
      out_hi_q <= acc_hi_q;
      out_dz_q <= dz_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign low_word_o       = out_lo_q;
  assign high_word_o      = out_hi_q;
  assign divide_by_zero_o = out_dz_q;

  // A completed remainder leaves a value below the divisor in the low word only.
  a_rem_high_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish && (func_q == FUNC_REM) && !dz_q |-> (acc_hi_q == '0))
    else $error("remainder left high word set");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish && (func_q == FUNC_REM) && !dz_q |-> (acc_lo_q < opa_q))
    else $error("remainder not below divisor");

  a_dz_only_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish && dz_q |-> (func_q == FUNC_REM) && (opa_q == '0))
    else $error("divide-by-zero flag without zero-divisor remainder");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_ready_o)
    else $error("ready right after accepting a transaction");

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.finish |-> out_free)
    else $error("result register overwritten while occupied");

endmodule
